FILE: rtl/core/ppit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppit_pkg
// Shared types and constants of the point-in-polygon tester.
// ----------------------------------------------------------------------------
package ppit_pkg;

  localparam int unsigned MaxVerticesDef = 256;
  localparam int unsigned CoordBitsDef   = 16;

  localparam int unsigned CmdW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_take;   // latch the point and reset the result flags
    logic set_empty;
    logic set_full;
    logic clr_count;
    logic append;
    logic walk_start;
    logic walk_issue;  // read one vertex of the table
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic last_addr;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/ppit_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppit_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppit_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/ppit_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppit_ctrl
// Controller: decodes each item and sequences the walk over the edge table.
// ----------------------------------------------------------------------------
module ppit_ctrl
  import ppit_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [CmdW-1:0] cmd_i,
  input  wire dp_status_t      status_i,
  output ctrl_cmd_t            cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_take = 1'b1;
          state_d         = ST_DONE;
          case (cmd_i)
            CMD_CLEAR: begin
              cmd_o.clr_count = 1'b1;
            end
            CMD_APPEND: begin
              if (status_i.cnt_full) begin
                cmd_o.set_full = 1'b1;
              end else begin
                cmd_o.append = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (status_i.cnt_zero) begin
                cmd_o.set_empty = 1'b1;
              end else begin
                cmd_o.walk_start = 1'b1;
                state_d          = ST_WALK;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd_o.walk_issue = 1'b1;
        if (status_i.last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded into a busy output register");

  a_walk_needs_vertices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk_start |-> !status_i.cnt_zero)
    else $error("walk started over an empty table");

  a_drain_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && status_i.last_addr) |=> state_q == ST_DRAIN)
    else $error("walk did not hand over to drain");

endmodule
`default_nettype wire

FILE: rtl/core/ppit_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppit_dpath
// Datapath: vertex table, edge fetch, crossing pipeline and result register.
// ----------------------------------------------------------------------------
module ppit_dpath
  import ppit_pkg::*;
#(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned CoordBits   = CoordBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [CoordBits-1:0] coord_x_i,
  input  wire logic [CoordBits-1:0] coord_y_i,
  input  wire ctrl_cmd_t            cmd_i,
  output dp_status_t                status_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                out_flags_o
);

  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * CoordBits + 2;

  // Vertex count and query point.
  logic [CW-1:0]        cnt_q;
  logic [CoordBits-1:0] px_q, py_q;

  // Table read side.
  logic [AW-1:0]          rd_addr_q;
  logic                   rv_q, rl_q, close_q, first_q;
  logic [2*CoordBits-1:0] rdata;
  logic [CoordBits-1:0]   rd_x, rd_y;
  logic [CoordBits-1:0]   fx_q, fy_q, vx_q, vy_q;

  // Edge stage.
  logic                 e1_v_q;
  logic [CoordBits-1:0] x1_q, y1_q, x2_q, y2_q;

  // Difference stage.
  logic                 s2_v_q;
  logic signed [DW-1:0] lx_q, dx_q, ady_q, aty_q;
  logic signed [DW-1:0] lx_d, dx_d, dy_d, ty_d, ady_d, aty_d;
  logic                 straddle;

  // Product stage.
  logic                 s3_v_q;
  logic signed [PW-1:0] p1_q, p2_q;

  // Result flags: bit 0 inside (crossing parity), bit 1 empty, bit 2 full.
  logic [2:0] res_q;
  logic       out_valid_q;
  logic [2:0] out_flags_q;
  logic       out_free;

  ppit_ram #(
    .Width (2 * CoordBits),
    .Depth (MaxVertices)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({coord_y_i, coord_x_i}),
    .re_i    (cmd_i.walk_issue),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[CoordBits-1:0];
  assign rd_y = rdata[2*CoordBits-1:CoordBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_count) begin
      cnt_q <= '0;
    end else if (cmd_i.append) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_take) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
  end

  // Read side control: the last read is followed by the closing edge back to
  // the first vertex.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rv_q      <= 1'b0;
      rl_q      <= 1'b0;
      close_q   <= 1'b0;
      first_q   <= 1'b0;
      e1_v_q    <= 1'b0;
    end else begin
      rv_q    <= cmd_i.walk_issue;
      rl_q    <= cmd_i.walk_issue && status_o.last_addr;
      close_q <= rv_q && rl_q;
      e1_v_q  <= (rv_q && !first_q) || close_q;
      if (cmd_i.walk_start) begin
        rd_addr_q <= '0;
        first_q   <= 1'b1;
      end else begin
        if (cmd_i.walk_issue) begin
          rd_addr_q <= rd_addr_q + AW'(1);
        end
        if (rv_q) begin
          first_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      vx_q <= rd_x;
      vy_q <= rd_y;
      if (first_q) begin
        fx_q <= rd_x;
        fy_q <= rd_y;
      end else begin
        x1_q <= vx_q;
        y1_q <= vy_q;
        x2_q <= rd_x;
        y2_q <= rd_y;
      end
    end else if (close_q) begin
      x1_q <= vx_q;
      y1_q <= vy_q;
      x2_q <= fx_q;
      y2_q <= fy_q;
    end
  end

  // Exact test: px - x1 < dx * ty / dy is lx * |dy| < dx * |ty|, since ty and
  // dy share a sign whenever the edge straddles the query height.
  always_comb begin
    straddle = ($signed(y1_q) > $signed(py_q)) != ($signed(y2_q) > $signed(py_q));
    lx_d  = DW'($signed(px_q)) - DW'($signed(x1_q));
    dx_d  = DW'($signed(x2_q)) - DW'($signed(x1_q));
    dy_d  = DW'($signed(y2_q)) - DW'($signed(y1_q));
    ty_d  = DW'($signed(py_q)) - DW'($signed(y1_q));
    ady_d = dy_d[DW-1] ? -dy_d : dy_d;
    aty_d = ty_d[DW-1] ? -ty_d : ty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s2_v_q <= e1_v_q && straddle;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lx_q  <= lx_d;
    dx_q  <= dx_d;
    ady_q <= ady_d;
    aty_q <= aty_d;
    p1_q  <= PW'(lx_q) * PW'(ady_q);
    p2_q  <= PW'(dx_q) * PW'(aty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (cmd_i.item_take) begin
      res_q <= {cmd_i.set_full, cmd_i.set_empty, 1'b0};
    end else if (s3_v_q && (p1_q < p2_q)) begin
      res_q[0] <= ~res_q[0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_flags_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_flags_o = out_flags_q;

  always_comb begin
    status_o.cnt_zero  = (cnt_q == '0);
    status_o.cnt_full  = (cnt_q == CW'(MaxVertices));
    status_o.last_addr = (CW'(rd_addr_q) == cnt_q - CW'(1));
    status_o.pipe_busy = rv_q || close_q || e1_v_q || s2_v_q || s3_v_q;
    status_o.out_free  = out_free;
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxVertices))
    else $error("vertex count beyond table depth");

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_issue |-> CW'(rd_addr_q) < cnt_q)
    else $error("read beyond stored vertices");

  a_append_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> cnt_q < CW'(MaxVertices))
    else $error("append into a full table");

  a_close_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_q |-> !rv_q)
    else $error("closing edge collides with a table read");

endmodule
`default_nettype wire

FILE: rtl/core/polygon_point_inside_test.sv
`default_nettype none
// Clear, append and unused commands pass from idle to the done state; a query
// over N stored vertices walks the vertex RAM at one read per cycle and then
// passes the difference, product and parity stages. A new item is taken only
// after the last result is loaded into the output register. Reset clears the
// vertex count and all control state; the vertex RAM is not cleared.
// ----------------------------------------------------------------------------
// polygon_point_inside_test
// Even-odd point-in-polygon tester over a stored vertex table, stream ports.
// ----------------------------------------------------------------------------
module polygon_point_inside_test
  import ppit_pkg::*;
#(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned CoordBits   = CoordBitsDef,
  localparam int unsigned InW = ((CmdW + 2 * CoordBits + 7) / 8) * 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // cmd, coord_x, coord_y
  input  wire logic [InW-1:0] s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  // inside_res, polygon_empty, table_full
  output logic [7:0]          m_axis_tdata_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  logic [2:0] out_flags;

  ppit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tdata_i[CmdW-1:0]),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  ppit_dpath #(
    .MaxVertices (MaxVertices),
    .CoordBits   (CoordBits)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coord_x_i   (s_axis_tdata_i[CmdW+CoordBits-1:CmdW]),
    .coord_y_i   (s_axis_tdata_i[CmdW+2*CoordBits-1:CmdW+CoordBits]),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_flags_o (out_flags)
  );

  assign m_axis_tdata_o = {5'b0, out_flags};

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point-in-polygon tester. Items go in through the
// input stream with random gaps. A local even-odd model predicts one answer
// per accepted item. Each answer taken from the output stream is compared
// with the oldest prediction. Random stalls, one long receiver hold and full
// drains exercise the flow control.
// ----------------------------------------------------------------------------
module tb_top;
  import ppit_pkg::*;

  localparam int unsigned InW         = ((CmdW + 2 * CoordBitsDef + 7) / 8) * 8;
  localparam int unsigned PadW        = InW - CmdW - 2 * CoordBitsDef;
  localparam int unsigned ItemTarget  = 1650;
  localparam int unsigned CycleLimit  = 3000000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = MaxVerticesDef + 40;
  localparam logic [CmdW-1:0] CmdReserved = 2'd3;

  typedef logic signed [CoordBitsDef-1:0] coord_t;

  typedef struct packed {
    logic in_poly;
    logic empty;
    logic full;
  } answer_t;

  logic           clk            = 1'b0;
  logic           rst_n          = 1'b0;
  logic           s_axis_tvalid  = 1'b0;
  logic           s_axis_tready;
  logic [InW-1:0] s_axis_tdata   = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready  = 1'b0;
  logic [7:0]     m_axis_tdata;

  // Vertex ring as the block should hold it, and the answers still owed.
  coord_t      ring_x [MaxVerticesDef];
  coord_t      ring_y [MaxVerticesDef];
  int unsigned ring_count = 0;
  answer_t     answers_due [$];

  int unsigned err_cnt    = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt  = 0;
  bit          steady     = 1'b0;
  logic        hold_req   = 1'b0;

  polygon_point_inside_test u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Even-odd crossing count against the closed ring, exact in 64-bit math.
  function automatic logic point_in_ring(coord_t qx, coord_t qy);
    int unsigned n, j;
    longint px, py, x1, y1, x2, y2, lx, dx, dy, ty;
    logic odd;
    odd = 1'b0;
    px  = qx;
    py  = qy;
    for (n = 0; n < ring_count; n++) begin
      j  = (n + 1 == ring_count) ? 0 : n + 1;
      x1 = ring_x[n];
      y1 = ring_y[n];
      x2 = ring_x[j];
      y2 = ring_y[j];
      if ((y1 > py) != (y2 > py)) begin
        lx = px - x1;
        dx = x2 - x1;
        dy = y2 - y1;
        ty = py - y1;
        // px left of the edge at height py, without dividing by dy.
        if (lx * (dy < 0 ? -dy : dy) < dx * (ty < 0 ? -ty : ty)) odd = ~odd;
      end
    end
    return odd;
  endfunction

  function automatic answer_t polygon_answer(logic [CmdW-1:0] code, coord_t x, coord_t y);
    answer_t a;
    a = '0;
    case (code)
      CMD_CLEAR: ring_count = 0;
      CMD_APPEND: begin
        if (ring_count < MaxVerticesDef) begin
          ring_x[ring_count] = x;
          ring_y[ring_count] = y;
          ring_count++;
        end else begin
          a.full = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (ring_count == 0) a.empty = 1'b1;
        else a.in_poly = point_in_ring(x, y);
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // Random point around c; the sum wraps at the coordinate width on purpose.
  function automatic coord_t near(coord_t c, int unsigned spread);
    return coord_t'(int'(c) + int'($urandom_range(2 * spread)) - int'(spread));
  endfunction

  // Leaves tvalid high after the handshake; a drain, or the next call when it
  // idles first, lowers it in the same step, so valid never gets two updates in one step.
  task automatic send_item(logic [CmdW-1:0] code, coord_t x, coord_t y);
    int unsigned gap;
    answer_t     due;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PadW{1'b0}}, y, x, code};
    do @(posedge clk); while (!s_axis_tready);
    due         = polygon_answer(code, x, y);
    answers_due = {answers_due, due};
    if (code != CmdReserved) items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  task automatic test_directed();
    send_item(CMD_QUERY, 0, 0);
    send_item(CmdReserved, -32768, 32767);
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_APPEND, -32768, -32768);
    send_item(CMD_APPEND, 32767, -32768);
    send_item(CMD_APPEND, 32767, 32767);
    send_item(CMD_APPEND, -32768, 32767);
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_QUERY, -32768, -32768);
    send_item(CMD_QUERY, 32767, 0);
    send_item(CMD_QUERY, -32768, 0);
    send_item(CMD_QUERY, 0, 32767);
    // An unused command must leave the stored square alone.
    send_item(CmdReserved, 0, 0);
    send_item(CMD_QUERY, -1, -1);
    send_item(CMD_CLEAR, 32767, 32767);
    send_item(CMD_APPEND, 0, 0);
    send_item(CMD_QUERY, -1, 0);
    send_item(CMD_APPEND, 0, 100);
    send_item(CMD_QUERY, -5, 50);
    send_item(CMD_QUERY, 5, 0);
  endtask

  task automatic test_full_table();
    int unsigned k;
    send_item(CMD_CLEAR, 0, 0);
    for (k = 0; k < MaxVerticesDef; k++) send_item(CMD_APPEND, rand_coord(), rand_coord());
    send_item(CMD_APPEND, 32767, -32768);
    send_item(CMD_APPEND, rand_coord(), rand_coord());
    for (k = 0; k < 4; k++) send_item(CMD_QUERY, rand_coord(), rand_coord());
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_QUERY, rand_coord(), rand_coord());
  endtask

  task automatic test_backpressure();
    int unsigned k;
    steady = 1'b1;
    send_item(CMD_CLEAR, 0, 0);
    hold_req <= 1'b1;
    send_item(CMD_APPEND, -1000, -1000);
    send_item(CMD_APPEND, 1000, -1000);
    send_item(CMD_APPEND, 0, 1500);
    for (k = 0; k < 10; k++) send_item(CMD_QUERY, near(0, 1600), near(0, 1600));
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_random();
    coord_t      vx [$];
    coord_t      vy [$];
    coord_t      cx, cy, x1, y1, qx, qy;
    int unsigned spread, nv, nq, a, b, k;
    while (items_sent < ItemTarget) begin
      steady = ($urandom_range(9) == 0);
      if ($urandom_range(99) < 85) begin
        vx.delete();
        vy.delete();
        send_item(CMD_CLEAR, rand_coord(), rand_coord());
        spread = ($urandom_range(4) == 0) ? 32767 : (1 << $urandom_range(13, 1));
        cx = rand_coord();
        cy = rand_coord();
        if ($urandom_range(4) == 0) begin
          // Axis-aligned box: two of its edges are horizontal.
          x1 = near(cx, spread);
          y1 = near(cy, spread);
          vx = {vx, cx}; vy = {vy, cy};
          vx = {vx, x1}; vy = {vy, cy};
          vx = {vx, x1}; vy = {vy, y1};
          vx = {vx, cx}; vy = {vy, y1};
        end else begin
          nv = ($urandom_range(9) == 0) ? $urandom_range(60, 11) : $urandom_range(10, 1);
          for (k = 0; k < nv; k++) begin
            vx = {vx, near(cx, spread)};
            vy = {vy, near(cy, spread)};
          end
        end
        for (k = 0; k < vx.size(); k++) send_item(CMD_APPEND, vx[k], vy[k]);
        nq = $urandom_range(20, 4);
        for (k = 0; k < nq; k++) begin
          a = $urandom_range(vx.size() - 1);
          b = $urandom_range(vx.size() - 1);
          case ($urandom_range(4))
            0: begin qx = near(vx[a], spread); qy = near(vy[a], spread); end
            // Query exactly at a vertex height.
            1: begin qx = near(vx[a], spread); qy = vy[a]; end
            2: begin
              qx = coord_t'((int'(vx[a]) + int'(vx[b])) / 2);
              qy = coord_t'((int'(vy[a]) + int'(vy[b])) / 2);
            end
            3: begin qx = vx[a]; qy = near(vy[a], spread); end
            default: begin qx = rand_coord(); qy = rand_coord(); end
          endcase
          send_item(CMD_QUERY, qx, qy);
        end
      end else begin
        case ($urandom_range(3))
          0: send_item(CmdReserved, rand_coord(), rand_coord());
          1: send_item(CMD_QUERY, rand_coord(), rand_coord());
          2: send_item(CMD_APPEND, rand_coord(), rand_coord());
          default: begin
            send_item(CMD_CLEAR, rand_coord(), rand_coord());
            send_item(CMD_QUERY, rand_coord(), rand_coord());
          end
        endcase
      end
    end
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req      <= 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall != 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (!steady && $urandom_range(99) < 20) begin
        stall = ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom_range(40, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    answer_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result item: tdata %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tdata[0] !== want.in_poly) begin
          $error("inside_res: expected %0d, got %0d", want.in_poly, m_axis_tdata[0]);
          err_cnt++;
        end
        if (m_axis_tdata[1] !== want.empty) begin
          $error("polygon_empty: expected %0d, got %0d", want.empty, m_axis_tdata[1]);
          err_cnt++;
        end
        if (m_axis_tdata[2] !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, m_axis_tdata[2]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : main_seq
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/ppit_pkg.sv
rtl/core/ppit_ram.sv
rtl/core/ppit_ctrl.sv
rtl/core/ppit_dpath.sv
rtl/core/polygon_point_inside_test.sv
bench/tb_top.sv
